// ===== rtl/refcounted_entry_cache_lru_unit_assert.svh =====
// Assertion macros for the cache datapath.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef REFCOUNTED_ENTRY_CACHE_LRU_UNIT_ASSERT_SVH
`define REFCOUNTED_ENTRY_CACHE_LRU_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RECL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define RECL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/recl_pkg.sv =====
`default_nettype none
package recl_pkg;

  // Table geometry and field widths.
  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = SLOT_W + 1;
  localparam int LEN_W  = $clog2(SLOTS + 1);
  localparam int DEV_W  = 32;
  localparam int KEY_W  = 32;
  localparam int REFS_W = 16;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUP     = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_TOO_HIGH  = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  // One stored slot.
  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [KEY_W-1:0]  key;
    logic [REFS_W-1:0] refs;
  } ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic init;
    logic scan_start;
    logic scan;
    logic fetch;
    logic take_head;
    logic inc;
    logic sub;
    logic clr_key;
    logic wr_ent;
    logic unlink;
    logic push_head;
    logic push_tail;
    logic emit;
  } cmd_t;

  // Result flags decided by the controller.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic              load;
    logic              rel;
    logic              fr;
    logic              use_cur;
  } res_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              live;
    logic              match;
    logic              scan_end;
    logic [MODE_W-1:0] mode;
    logic              key_zero;
    logic              dev_nonzero;
    logic              refs_zero;
    logic              refs_max;
    logic              sub_big;
    logic              sub_zero;
    logic              unl;
    logic              len_zero;
    logic              out_valid;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/recl_datapath.sv =====
`default_nettype none
module recl_datapath
  import recl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [95:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tready,
  input  wire cmd_t        cmd,
  input  wire res_t        res,
  output stat_t            stat,
  output logic             m_tvalid,
  output logic [31:0]      m_tdata
);

  `include "refcounted_entry_cache_lru_unit_assert.svh"

  // Captured request.
  logic [MODE_W-1:0] mode_q;
  logic [DEV_W-1:0]  dev_q;
  logic [KEY_W-1:0]  key_q;
  logic [REFS_W-1:0] rcnt_q;
  logic              unl_q;
  logic [SLOT_W-1:0] sin_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= s_tuser;
      dev_q  <= s_tdata[31:0];
      key_q  <= s_tdata[63:32];
      rcnt_q <= s_tdata[79:64];
      unl_q  <= s_tdata[80];
      sin_q  <= s_tdata[88:81];
    end
  end

  // Sweep counter, shared by the clearing pass and the key search.
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan || cmd.init) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Current slot under work.
  logic [SLOT_W-1:0] cur_slot;
  logic [DEV_W-1:0]  cur_dev;
  logic [KEY_W-1:0]  cur_key;
  logic [REFS_W-1:0] cur_refs;

  // Entry memory with a registered read port.
  ent_t              ent_mem [SLOTS];
  ent_t              ent_rd;
  logic [SLOT_W-1:0] ent_raddr;
  logic [SLOT_W-1:0] rd_addr;
  logic              live_scan;
  logic              live_fetch;
  logic              match;

  assign ent_raddr = cmd.fetch ? sin_q : idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    ent_rd  <= ent_mem[ent_raddr];
    rd_addr <= ent_raddr;
    if (cmd.init) begin
      ent_mem[idx[SLOT_W-1:0]] <= '0;
    end else if (cmd.wr_ent) begin
      ent_mem[cur_slot] <= '{dev: cur_dev, key: cur_key, refs: cur_refs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_scan  <= 1'b0;
      live_fetch <= 1'b0;
    end else begin
      live_scan  <= cmd.scan;
      live_fetch <= cmd.fetch;
    end
  end

  // A get matches any slot holding the device and key; other requests need a referenced slot.
  assign match = live_scan && (ent_rd.key == key_q) && (ent_rd.dev == dev_q) &&
                 ((mode_q == MODE_GET) || (ent_rd.refs != '0));

  // Free list head, tail and length.
  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [LEN_W-1:0]  len, len_next;

  // Current slot register updates.
  always_ff @(posedge clk) begin
    if (match || live_fetch) begin
      cur_slot <= rd_addr;
      cur_dev  <= ent_rd.dev;
      cur_key  <= ent_rd.key;
      cur_refs <= ent_rd.refs;
    end else if (cmd.take_head) begin
      cur_slot <= head;
      cur_dev  <= dev_q;
      cur_key  <= key_q;
      cur_refs <= REFS_W'(1);
    end else begin
      if (cmd.inc) begin
        cur_refs <= cur_refs + REFS_W'(1);
      end else if (cmd.sub) begin
        cur_refs <= cur_refs - rcnt_q;
      end
      if (cmd.clr_key) begin
        cur_key <= '0;
      end
    end
  end

  // Link memories, read at the current slot.
  logic [SLOT_W-1:0] nxt_mem [SLOTS];
  logic [SLOT_W-1:0] prv_mem [SLOTS];
  logic [SLOT_W-1:0] nxt_rd, prv_rd;
  logic              nxt_we, prv_we;
  logic [SLOT_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  always_ff @(posedge clk) begin
    nxt_rd <= nxt_mem[cur_slot];
    prv_rd <= prv_mem[cur_slot];
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
  end

  // List edits: clearing pass, removal, push at head or tail.
  always_comb begin
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    nxt_wa    = cur_slot;
    nxt_wd    = head;
    prv_wa    = head;
    prv_wd    = cur_slot;
    head_next = head;
    tail_next = tail;
    len_next  = len;
    if (cmd.init) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      nxt_wa = idx[SLOT_W-1:0];
      prv_wa = idx[SLOT_W-1:0];
      nxt_wd = idx[SLOT_W-1:0] - SLOT_W'(1);
      prv_wd = idx[SLOT_W-1:0] + SLOT_W'(1);
    end else if (cmd.unlink) begin
      if (len == LEN_W'(1)) begin
        len_next = '0;
      end else if (len != '0) begin
        if (cur_slot == head) begin
          head_next = nxt_rd;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd;
          nxt_wd = nxt_rd;
        end
        if (cur_slot == tail) begin
          tail_next = prv_rd;
        end else begin
          prv_we = 1'b1;
          prv_wa = nxt_rd;
          prv_wd = prv_rd;
        end
        len_next = len - LEN_W'(1);
      end
    end else if (cmd.push_head) begin
      if (len == '0) begin
        head_next = cur_slot;
        tail_next = cur_slot;
      end else begin
        nxt_we    = 1'b1;
        nxt_wa    = cur_slot;
        nxt_wd    = head;
        prv_we    = 1'b1;
        prv_wa    = head;
        prv_wd    = cur_slot;
        head_next = cur_slot;
      end
      len_next = len + LEN_W'(1);
    end else if (cmd.push_tail) begin
      if (len == '0) begin
        head_next = cur_slot;
        tail_next = cur_slot;
      end else begin
        prv_we    = 1'b1;
        prv_wa    = cur_slot;
        prv_wd    = tail;
        nxt_we    = 1'b1;
        nxt_wa    = tail;
        nxt_wd    = cur_slot;
        tail_next = cur_slot;
      end
      len_next = len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= SLOT_W'(SLOTS - 1);
      tail <= '0;
      len  <= LEN_W'(SLOTS);
    end else begin
      head <= head_next;
      tail <= tail_next;
      len  <= len_next;
    end
  end

  // Output register.
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic [STAT_W-1:0] out_status;
  logic              out_hit, out_load, out_rel, out_fr;
  logic [REFS_W-1:0] out_refs;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot   <= res.use_cur ? cur_slot : '0;
      out_refs   <= res.use_cur ? cur_refs : '0;
      out_status <= res.status;
      out_hit    <= res.hit;
      out_load   <= res.load;
      out_rel    <= res.rel;
      out_fr     <= res.fr;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_fr, out_rel, out_refs, out_load, out_hit, out_status, out_slot};

  // Status toward the controller.
  always_comb begin
    stat.live        = live_scan;
    stat.match       = match;
    stat.scan_end    = (idx == IDX_W'(SLOTS));
    stat.mode        = mode_q;
    stat.key_zero    = (key_q == '0);
    stat.dev_nonzero = (dev_q != '0);
    stat.refs_zero   = (cur_refs == '0);
    stat.refs_max    = (cur_refs == REFS_MAX);
    stat.sub_big     = (rcnt_q > cur_refs);
    stat.sub_zero    = (rcnt_q == cur_refs);
    stat.unl         = unl_q;
    stat.len_zero    = (len == '0);
    stat.out_valid   = out_valid;
  end

  `RECL_ASSERT(a_len_bound, len <= LEN_W'(SLOTS), "free list longer than the table")
  `RECL_ASSERT(a_unlink_nonempty, !cmd.unlink || (len != '0), "removal from an empty free list")
  `RECL_ASSERT(a_push_room, !(cmd.push_head || cmd.push_tail) || (len != LEN_W'(SLOTS)), "push onto a full free list")
  `RECL_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "emitted beat not presented")

endmodule
`default_nettype wire

// ===== rtl/recl_ctrl.sv =====
`default_nettype none
module recl_ctrl
  import recl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  input  wire logic  m_tready,
  input  wire stat_t stat,
  output logic       s_tready,
  output cmd_t       cmd,
  output res_t       res
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_FETCHW = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_LWAIT  = 4'd6;
  localparam logic [3:0] S_UNLINK = 4'd7;
  localparam logic [3:0] S_WRBACK = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state, state_next;
  res_t       res_next;

  assign s_tready = (state == S_IDLE);

  // Sequencing of each request.
  always_comb begin
    cmd        = '0;
    state_next = state;
    res_next   = res;
    case (state)
      S_INIT: begin
        if (stat.scan_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.init = 1'b1;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        res_next = '0;
        if (stat.mode == MODE_DUP) begin
          cmd.fetch  = 1'b1;
          state_next = S_FETCHW;
        end else if (stat.key_zero) begin
          res_next.status = ST_NOT_FOUND;
          state_next      = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_FETCHW: begin
        state_next = S_EVAL;
      end
      S_SCAN: begin
        if (stat.match) begin
          state_next = S_EVAL;
        end else if (stat.scan_end && !stat.live) begin
          // No slot matches the request.
          if (stat.mode != MODE_GET) begin
            res_next.status = ST_NOT_FOUND;
            state_next      = S_FINISH;
          end else if (stat.len_zero) begin
            res_next.status = ST_NO_FREE;
            state_next      = S_FINISH;
          end else begin
            cmd.take_head    = 1'b1;
            res_next.status  = ST_OK;
            res_next.load    = stat.dev_nonzero;
            res_next.use_cur = 1'b1;
            state_next       = S_LWAIT;
          end
        end else if (!stat.scan_end) begin
          cmd.scan = 1'b1;
        end
      end
      S_EVAL: begin
        res_next.hit     = 1'b1;
        res_next.use_cur = 1'b1;
        res_next.status  = ST_OK;
        state_next       = S_FINISH;
        case (stat.mode)
          MODE_FIND: begin
          end
          MODE_GET: begin
            if (stat.refs_max) begin
              res_next.status = ST_OVERFLOW;
            end else begin
              cmd.inc    = 1'b1;
              state_next = stat.refs_zero ? S_LWAIT : S_WRBACK;
            end
          end
          MODE_RELEASE: begin
            if (stat.sub_big) begin
              res_next.status = ST_TOO_HIGH;
            end else begin
              cmd.sub    = 1'b1;
              state_next = S_WRBACK;
              if (stat.sub_zero) begin
                res_next.rel  = 1'b1;
                res_next.fr   = stat.unl;
                cmd.clr_key   = stat.unl;
                cmd.push_head = stat.unl;
                cmd.push_tail = !stat.unl;
              end
            end
          end
          default: begin
            // Reference added by slot number.
            if (stat.refs_zero) begin
              res_next = '0;
              res_next.status = ST_NOT_FOUND;
            end else if (stat.refs_max) begin
              res_next.status = ST_OVERFLOW;
            end else begin
              cmd.inc    = 1'b1;
              state_next = S_WRBACK;
            end
          end
        endcase
      end
      S_LWAIT: begin
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_WRBACK;
      end
      S_WRBACK: begin
        cmd.wr_ent = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      res   <= '0;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/refcounted_entry_cache_lru_unit.sv =====
`default_nettype none
// Reference-counted entry cache with a least-recently-used free list. After reset
// the block runs a clearing pass over all 256 slots of its slot and link memories
// and takes no request until it ends. Each request then gives one result beat,
// and the block is ready for the next request once that beat is loaded into the
// output register. A find, get or release searches the slots one per cycle from
// slot 0 until a slot matches the device and key. A get hit on a free slot also
// removes that slot from the free list, and a get that finds nothing takes the
// free list head, or is answered with no free slot when the list is empty. An
// add-reference request names its slot directly and is answered as not found when
// the slot is not in use. A find, get or release with a key number of zero is
// answered as not found without a search. A beat still waiting for the receiver
// holds back the next one.
module refcounted_entry_cache_lru_unit
  import recl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // device[31:0], key_number[63:32], release_count[79:64], unlinked[80],
  // slot_in[88:81], zero above
  input  wire logic [95:0] s_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // slot[7:0], status[10:8], was_hit[11], need_load[12], refs_after[28:13],
  // released[29], freed[30], zero above
  output logic [31:0]      m_tdata
);

  cmd_t  cmd;
  res_t  res;
  stat_t stat;

  // Request sequencer.
  recl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd),
    .res      (res)
  );

  // Slot table, free list and output register.
  recl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .cmd      (cmd),
    .res      (res),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
